### hdl/lcw_pkg.sv
// Shared types and constants for the load-cell weight readout.
// No dependencies; design files use scoped names, the bench imports it.
package lcw_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int DIGIT_COUNT_DEF = 5;

	localparam int TARE_W   = 24;
	localparam int WEIGHT_W = 16;
	localparam int SCALE_W  = 16;
	localparam int BYTE_W   = 8;
	localparam int SLOT_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [TARE_W-1:0]   TARE_RST   = 24'd0;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd22938;
	localparam logic [SCALE_W-1:0]  SCALE_RST  = 16'd57700;

	// Q16 unity for the smoothing weight, Q0.20 scale shift
	localparam int Q16_SHIFT   = 16;
	localparam int SCALE_SHIFT = 20;

	localparam int ZERO_OFFSET = 512;
	localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;

	// floor(x / 10) = (x * RECIP10) >> RECIP10_SHIFT, exact for any 32-bit x
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
	localparam int RECIP10_SHIFT = 35;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARE   = 2'd0,
		CFG_WEIGHT = 2'd1,
		CFG_SCALE  = 2'd2,
		CFG_NONE   = 2'd3
	} cfg_idx_t;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

endpackage

### hdl/lcw_if.sv
// Channel interfaces for the load-cell weight readout: items, results, register writes.
// Depends on lcw_pkg for field widths.
interface lcw_item_if #(
	parameter int SAMPLE_BITS = lcw_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic                   func;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output func, output sample, input ready);
	modport sink   (input valid, input func, input sample, output ready);
endinterface

interface lcw_result_if;
	logic                        valid;
	logic                        ready;
	logic [lcw_pkg::BYTE_W-1:0]  data_byte;
	logic [lcw_pkg::SLOT_W-1:0]  slot;

	modport source (output valid, output data_byte, output slot, input ready);
	modport sink   (input valid, input data_byte, input slot, output ready);
endinterface

interface lcw_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [lcw_pkg::CFG_IDX_W-1:0]   index;
	logic [lcw_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/load_cell_weight_readout.sv
// Load-cell weight readout: smoothing filter, gram conversion, ASCII frame reads.
// Depends on lcw_pkg and the channel interfaces in lcw_if.sv.
//
//  channel  role    payload                       transfer
//  item     sink    func, sample                  valid & ready
//  result   source  data_byte, slot               valid & ready
//  cfg      sink    index, data                   valid & ready (ready always high)
//
// One item is taken per cycle while the pipeline advances. A read result passes an
// offset stage, the scale multiply, the clamp, and one divide-by-ten stage per digit
// below the top one, then the output register.
// Reset clears the filter, latch, read slot, digits and registers to their defaults.
// While the output register holds an untaken result, the whole pipeline holds and
// item.ready is low. Samples give no result, but occupy a stage and set the digits.
module load_cell_weight_readout #(
	parameter int SAMPLE_BITS = lcw_pkg::SAMPLE_BITS_DEF,
	parameter int DIGIT_COUNT = lcw_pkg::DIGIT_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	lcw_item_if.sink      item,
	lcw_result_if.source  result,
	lcw_cfg_if.sink       cfg
);

	localparam int SB    = SAMPLE_BITS;
	localparam int D     = DIGIT_COUNT;
	localparam int SLW   = $clog2(D + 1);
	localparam longint unsigned LIMIT = 10**D - 1;
	localparam int GW    = $clog2(LIMIT + 1);
	localparam int GRW   = SB + lcw_pkg::SCALE_W - lcw_pkg::SCALE_SHIFT;
	localparam int CW    = (GRW > GW) ? GRW : GW;
	localparam int DW    = ((SB > lcw_pkg::TARE_W) ? SB : lcw_pkg::TARE_W) + 2;
	localparam int AW    = SB + lcw_pkg::WEIGHT_W + 2;
	localparam int QW    = GW - 3;
	localparam int NS    = D + 2;

	typedef struct packed {
		logic                      vld;
		logic                      rd;
		logic [SLW-1:0]            slot;
		logic [lcw_pkg::BYTE_W-1:0] fbyte;
	} ctl_t;

	// Registers
	logic [lcw_pkg::TARE_W-1:0]   tare_q;
	logic [lcw_pkg::WEIGHT_W-1:0] weight_q;
	logic [lcw_pkg::SCALE_W-1:0]  scale_q;

	// Architectural state
	logic [SB-1:0]  filt_q;
	logic [SB-1:0]  latch_q;
	logic [SLW-1:0] rslot_q;
	logic [lcw_pkg::BYTE_W-1:0] chars_q [D];

	// Pipeline
	ctl_t                        ctl_s [NS];
	logic [SB-1:0]               diff_s1;
	logic [lcw_pkg::SCALE_W-1:0] scale_s1;
	logic [GRW-1:0]              gram_s2;
	logic [GW-1:0]               work_s [D];
	logic [4*D-1:0]              digs_s [D];

	logic                        out_valid_q;
	logic [lcw_pkg::BYTE_W-1:0]  out_byte_q;
	logic [lcw_pkg::SLOT_W-1:0]  out_slot_q;

	logic adv, in_fire;
	logic [lcw_pkg::WEIGHT_W:0] wq;
	logic [AW-1:0]  acc;
	logic [SB-1:0]  filt_nxt;
	logic [DW-1:0]  diff;
	logic           diff_pos;
	logic [SLW-1:0] rslot_nxt;
	logic [SB+lcw_pkg::SCALE_W-1:0] prod;
	logic [CW-1:0]  gram_ext;

	assign adv     = !out_valid_q || result.ready;
	assign in_fire = item.valid && adv;
	assign item.ready = adv;
	assign cfg.ready  = 1'b1;

	assign result.valid     = out_valid_q;
	assign result.data_byte = out_byte_q;
	assign result.slot      = out_slot_q;

	always_comb begin
		wq  = (lcw_pkg::WEIGHT_W+1)'(1 << lcw_pkg::Q16_SHIFT) - {1'b0, weight_q};
		acc = AW'(wq * item.sample) + AW'(weight_q * filt_q);
		filt_nxt = acc[SB+lcw_pkg::Q16_SHIFT-1:lcw_pkg::Q16_SHIFT];
		diff = DW'(latch_q) - DW'(tare_q) - DW'(lcw_pkg::ZERO_OFFSET);
		diff_pos = !diff[DW-1] && (diff != '0);
		rslot_nxt = (rslot_q < SLW'(D)) ? rslot_q + SLW'(1) : '0;
		prod = diff_s1 * scale_s1;
		gram_ext = CW'(gram_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tare_q   <= lcw_pkg::TARE_RST;
			weight_q <= lcw_pkg::WEIGHT_RST;
			scale_q  <= lcw_pkg::SCALE_RST;
		end else if (cfg.valid) begin
			unique case (lcw_pkg::cfg_idx_t'(cfg.index))
				lcw_pkg::CFG_TARE:   tare_q   <= cfg.data[lcw_pkg::TARE_W-1:0];
				lcw_pkg::CFG_WEIGHT: weight_q <= cfg.data[lcw_pkg::WEIGHT_W-1:0];
				lcw_pkg::CFG_SCALE:  scale_q  <= cfg.data[lcw_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// State updates happen at the item transfer, in arrival order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q  <= '0;
			latch_q <= '0;
			rslot_q <= '0;
		end else if (in_fire) begin
			if (item.func == lcw_pkg::FUNC_SAMPLE) begin
				filt_q <= filt_nxt;
				if (rslot_q == '0) latch_q <= filt_nxt;
			end else begin
				rslot_q <= rslot_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) ctl_s[k] <= '0;
		end else if (adv) begin
			ctl_s[0].vld   <= in_fire;
			ctl_s[0].rd    <= item.func;
			ctl_s[0].slot  <= rslot_q;
			ctl_s[0].fbyte <= filt_q[lcw_pkg::BYTE_W-1:0];
			for (int k = 1; k < NS; k++) ctl_s[k] <= ctl_s[k-1];
		end
	end

	// Conversion datapath: offset, scale, clamp
	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s1  <= diff_pos ? diff[SB-1:0] : '0;
			scale_s1 <= scale_q;
			gram_s2  <= prod[SB+lcw_pkg::SCALE_W-1:lcw_pkg::SCALE_SHIFT];
			work_s[0] <= (gram_ext > CW'(LIMIT)) ? GW'(LIMIT) : gram_ext[GW-1:0];
		end
	end

	assign digs_s[0] = '0;

	// One divide-by-ten per stage; stage m peels off digit D-m
	for (genvar m = 1; m < D; m++) begin : g_div
		logic [GW+31:0] qprod;
		logic [QW-1:0]  q;
		logic [GW:0]    q10;
		logic [GW:0]    rem;
		logic [4*D-1:0] digs_nxt;

		always_comb begin
			qprod = work_s[m-1] * lcw_pkg::RECIP10;
			q     = qprod[GW+31:lcw_pkg::RECIP10_SHIFT];
			q10   = ((GW+1)'(q) << 3) + ((GW+1)'(q) << 1);
			rem   = (GW+1)'(work_s[m-1]) - q10;
			digs_nxt = digs_s[m-1];
			digs_nxt[4*(D-m)+:4] = rem[3:0];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				work_s[m] <= GW'(q);
				digs_s[m] <= digs_nxt;
			end
		end
	end

	// Last stage: a sample writes the digit characters, a read picks its byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int i = 0; i < D; i++) chars_q[i] <= '0;
		end else if (adv) begin
			out_valid_q <= ctl_s[NS-1].vld && ctl_s[NS-1].rd;
			if (ctl_s[NS-1].vld && !ctl_s[NS-1].rd) begin
				chars_q[0] <= lcw_pkg::ASCII_ZERO + lcw_pkg::BYTE_W'(work_s[D-1][3:0]);
				for (int i = 1; i < D; i++)
					chars_q[i] <= lcw_pkg::ASCII_ZERO + lcw_pkg::BYTE_W'(digs_s[D-1][4*i+:4]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s[NS-1].vld && ctl_s[NS-1].rd) begin
			out_slot_q <= lcw_pkg::SLOT_W'(ctl_s[NS-1].slot);
			if (ctl_s[NS-1].slot < SLW'(D))
				out_byte_q <= chars_q[ctl_s[NS-1].slot];
			else
				out_byte_q <= ctl_s[NS-1].fbyte;
		end
	end

endmodule

### tb/sv/tb.sv
// Self-checking bench for load_cell_weight_readout: samples and frame reads go in, a
// scoreboard tracks the filter, latch and digit frame and checks every byte in order.
// Depends on lcw_pkg, the channel interfaces in lcw_if.sv and the block itself.
module tb;
	import lcw_pkg::*;

	localparam int SW        = SAMPLE_BITS_DEF;
	localparam int DIGITS    = DIGIT_COUNT_DEF;
	localparam int PIPE_LAT  = DIGITS + 3;
	localparam int SETTLE    = PIPE_LAT + 8;
	localparam int STALL_MAX = 1000;
	localparam int SEGMENTS  = 10;
	localparam int SEG_ITEMS = 150;
	localparam int GRAMS_MAX = 10 ** DIGITS - 1;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic [SLOT_W-1:0] slot;
	} frame_byte_t;

	logic clk;
	logic arst_n;
	bit   quiet;
	int   errors = 0;
	int   stall_cycles = 0;

	// scoreboard copy of the registers and the readout state
	logic [TARE_W-1:0]   tare;
	logic [WEIGHT_W-1:0] weight;
	logic [SCALE_W-1:0]  scale;
	logic [SW-1:0]       smoothed;
	logic [SW-1:0]       held_raw;
	logic [BYTE_W-1:0]   shown_digits [DIGITS];
	logic [SLOT_W-1:0]   frame_pos;
	frame_byte_t         frame_bytes_due [$];
	frame_byte_t         due;

	lcw_item_if #(.SAMPLE_BITS(SW)) item_ch ();
	lcw_result_if                   result_ch ();
	lcw_cfg_if                      cfg_ch ();

	load_cell_weight_readout #(.SAMPLE_BITS(SW), .DIGIT_COUNT(DIGITS)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (errors < 200)
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	task automatic weigh_step(input logic f, input logic [SW-1:0] s);
		logic [63:0]        acc;
		logic signed [63:0] diff;
		logic [63:0]        grams;
		frame_byte_t        fb;
		if (f == FUNC_SAMPLE) begin
			acc = (64'd65536 - 64'(weight)) * 64'(s) + 64'(weight) * 64'(smoothed);
			// convert the latch as it stood before this sample
			diff = $signed(64'(held_raw)) - $signed(64'(tare)) - 64'(ZERO_OFFSET);
			grams = (diff > 0) ? ((64'(diff) * 64'(scale)) >> SCALE_SHIFT) : 64'd0;
			if (grams > GRAMS_MAX)
				grams = GRAMS_MAX;
			for (int i = DIGITS - 1; i >= 0; i--) begin
				shown_digits[i] = ASCII_ZERO + BYTE_W'(grams % 10);
				grams = grams / 10;
			end
			smoothed = acc[Q16_SHIFT +: SW];
			// hold the latch while a frame is being read out
			if (frame_pos == '0)
				held_raw = smoothed;
		end else begin
			fb.slot = frame_pos;
			if (frame_pos < DIGITS) begin
				fb.data_byte = shown_digits[frame_pos];
				frame_pos++;
			end else begin
				fb.data_byte = smoothed[BYTE_W-1:0];
				frame_pos = '0;
			end
			frame_bytes_due.push_back(fb);
		end
	endtask

	// Leave valid high after a transfer; the next call reuses it or the caller drops it.
	task automatic send_item(input logic f, input logic [SW-1:0] s);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		item_ch.valid  <= 1'b1;
		item_ch.func   <= f;
		item_ch.sample <= s;
		do @(posedge clk); while (!item_ch.ready);
		weigh_step(f, s);
	endtask

	task automatic read_byte();
		send_item(FUNC_READ, SW'($urandom()));
	endtask

	task automatic read_to_frame_end();
		do read_byte(); while (frame_pos != '0);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_TARE:   tare   = val[TARE_W-1:0];
			CFG_WEIGHT: weight = val[WEIGHT_W-1:0];
			CFG_SCALE:  scale  = val[SCALE_W-1:0];
			default:    ;
		endcase
	endtask

	// Drain the block, let queued samples clear the pipeline, then rewrite the registers.
	task automatic set_registers(input logic [TARE_W-1:0] t, input logic [WEIGHT_W-1:0] w,
		input logic [SCALE_W-1:0] sc);
		item_ch.valid <= 1'b0;
		while (frame_bytes_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		write_reg(CFG_NONE, CFG_DATA_W'($urandom()));
		write_reg(CFG_TARE, t);
		write_reg(CFG_WEIGHT, {8'($urandom()), w});
		write_reg(CFG_SCALE, {8'($urandom()), sc});
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_level(input int bits, input int typical);
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return CFG_DATA_W'((64'd1 << bits) - 1);
			default: return CFG_DATA_W'($urandom_range(0, typical));
		endcase
	endfunction

	// Aim most samples at the span that yields readable gram values.
	function automatic logic [SW-1:0] pick_sample();
		logic [SW:0] v;
		case ($urandom_range(0, 7))
			0:       v = (SW + 1)'($urandom());
			1:       v = $urandom_range(0, 1) ? {1'b0, {SW{1'b1}}} : '0;
			2:       v = {1'b0, tare} + (SW + 1)'(ZERO_OFFSET - 16) + (SW + 1)'($urandom_range(0, 32));
			default: v = {1'b0, tare} + (SW + 1)'(ZERO_OFFSET) + (SW + 1)'($urandom_range(0, 1 << 21));
		endcase
		return v[SW] ? {SW{1'b1}} : v[SW-1:0];
	endfunction

	task automatic run_traffic(input int n_items);
		int   sent;
		int   k;
		logic f;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 3) != 0) begin
				k = $urandom_range(1, 4);
				repeat (k) send_item(FUNC_SAMPLE, pick_sample());
				sent += k;
				while (frame_pos != '0 || sent < n_items) begin
					read_byte();
					sent++;
					if (frame_pos == '0)
						break;
				end
			end else begin
				repeat ($urandom_range(1, 8)) begin
					f = $urandom_range(0, 1);
					send_item(f, pick_sample());
					sent++;
				end
			end
		end
	endtask

	task automatic test_read_before_sample();
		repeat (DIGITS + 1) read_byte();
	endtask

	task automatic test_extremes();
		// first converts the empty latch, second overranges
		repeat (2) send_item(FUNC_SAMPLE, '1);
		repeat (3) read_byte();
		send_item(FUNC_SAMPLE, '0);
		repeat (DIGITS - 2) read_byte();
		repeat (2) send_item(FUNC_SAMPLE, '0);
		read_to_frame_end();
	endtask

	task automatic test_register_sweep();
		set_registers('1, '0, '1);
		run_traffic(20);
		set_registers('0, '1, '0);
		run_traffic(20);
		set_registers('0, '0, '1);
		read_to_frame_end();
		// walk across the zero point with an unfiltered latch
		send_item(FUNC_SAMPLE, SW'(ZERO_OFFSET));
		send_item(FUNC_SAMPLE, SW'(ZERO_OFFSET + 1));
		send_item(FUNC_SAMPLE, SW'(ZERO_OFFSET + 40));
		read_to_frame_end();
		run_traffic(20);
		set_registers(TARE_RST, WEIGHT_RST, SCALE_RST);
		run_traffic(20);
	endtask

	task automatic test_random_traffic();
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			set_registers(pick_level(TARE_W, 1 << 20), pick_level(WEIGHT_W, 65535),
				pick_level(SCALE_W, 65535));
			quiet = (seg == SEGMENTS - 1);
			run_traffic(SEG_ITEMS);
		end
	endtask

	initial begin
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(20, 60)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (frame_bytes_due.size() == 0) begin
				report_mismatch("result with nothing due, slot", result_ch.slot, -1);
			end else begin
				due = frame_bytes_due.pop_front();
				if (result_ch.data_byte !== due.data_byte)
					report_mismatch("data_byte", result_ch.data_byte, due.data_byte);
				if (result_ch.slot !== due.slot)
					report_mismatch("slot", result_ch.slot, due.slot);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_MAX) begin
			$display("load_cell_weight_readout test failed");
			$finish;
		end
	end

	initial begin
		item_ch.valid  = 1'b0;
		item_ch.func   = FUNC_SAMPLE;
		item_ch.sample = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = CFG_NONE;
		cfg_ch.data    = '0;
		arst_n         = 1'b0;
		quiet          = 1'b0;
		tare           = TARE_RST;
		weight         = WEIGHT_RST;
		scale          = SCALE_RST;
		smoothed       = '0;
		held_raw       = '0;
		frame_pos      = '0;
		for (int i = 0; i < DIGITS; i++)
			shown_digits[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_read_before_sample();
		test_extremes();
		test_register_sweep();
		test_random_traffic();
		item_ch.valid <= 1'b0;
		while (frame_bytes_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("load_cell_weight_readout test passed");
		else
			$display("load_cell_weight_readout test failed");
		$finish;
	end

endmodule
